// ===== rtl/core/dpalu_pkg.sv =====
// Shared types and codes for the data-processing ALU core.
// Holds the queue entry layout, the ALU function codes and the condition codes.
// No dependencies.
package dpalu_pkg;

	localparam int unsigned WordW      = 32;
	localparam int unsigned QueueDepth = 2;
	localparam int unsigned InDataW    = 4 * WordW;
	localparam int unsigned OutDataW   = 48;

	// data-processing opcodes, instruction bits 24:21
	localparam logic [3:0] OP_AND = 4'h0;
	localparam logic [3:0] OP_EOR = 4'h1;
	localparam logic [3:0] OP_SUB = 4'h2;
	localparam logic [3:0] OP_RSB = 4'h3;
	localparam logic [3:0] OP_ADD = 4'h4;
	localparam logic [3:0] OP_ADC = 4'h5;
	localparam logic [3:0] OP_SBC = 4'h6;
	localparam logic [3:0] OP_RSC = 4'h7;
	localparam logic [3:0] OP_TST = 4'h8;
	localparam logic [3:0] OP_TEQ = 4'h9;
	localparam logic [3:0] OP_CMP = 4'hA;
	localparam logic [3:0] OP_CMN = 4'hB;
	localparam logic [3:0] OP_ORR = 4'hC;
	localparam logic [3:0] OP_MOV = 4'hD;
	localparam logic [3:0] OP_BIC = 4'hE;
	localparam logic [3:0] OP_MVN = 4'hF;

	// shift kinds, instruction bits 6:5
	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	// condition codes, instruction bits 31:28
	localparam logic [3:0] COND_EQ = 4'h0;
	localparam logic [3:0] COND_NE = 4'h1;
	localparam logic [3:0] COND_CS = 4'h2;
	localparam logic [3:0] COND_CC = 4'h3;
	localparam logic [3:0] COND_MI = 4'h4;
	localparam logic [3:0] COND_PL = 4'h5;
	localparam logic [3:0] COND_VS = 4'h6;
	localparam logic [3:0] COND_VC = 4'h7;
	localparam logic [3:0] COND_HI = 4'h8;
	localparam logic [3:0] COND_LS = 4'h9;
	localparam logic [3:0] COND_GE = 4'hA;
	localparam logic [3:0] COND_LT = 4'hB;
	localparam logic [3:0] COND_GT = 4'hC;
	localparam logic [3:0] COND_LE = 4'hD;

	// what the back end computes
	typedef enum logic [2:0] {
		FN_AND,
		FN_EOR,
		FN_ORR,
		FN_MOV,
		FN_BIC,
		FN_MVN,
		FN_ADD
	} alu_fn_t;

	// carry into the adder
	typedef enum logic [1:0] {
		CIN_ZERO,
		CIN_ONE,
		CIN_FLAG
	} cin_kind_t;

	// one decoded instruction waiting for execution
	typedef struct packed {
		logic [3:0]       cond;
		logic [3:0]       rd;
		logic             set_flags;
		logic             writes;
		alu_fn_t          fn;
		logic             swap;       // adder takes operand 2 first, Rn second
		logic             invert;     // adder inverts its second input
		cin_kind_t        cin_kind;
		logic [WordW-1:0] rn;
		logic [WordW-1:0] op2;
		logic             shc;        // shifter carry when not taken from C
		logic             shc_from_c; // shifter carry is the old C flag
		logic             rrx;        // operand 2 bit 31 is the old C flag
	} op_item_t;

endpackage

// ===== rtl/core/dpalu_front.sv =====
// Front end: accepts instruction transfers, runs the barrel shifter and classifies the op.
// Carry-dependent shifter cases are marked for the back end to resolve.
// Depends on dpalu_pkg.
module dpalu_front (
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// instruction, first_value, second_value, shift_reg_value (lowest first)
	input  logic [dpalu_pkg::InDataW-1:0] s_tdata,
	input  logic                         q_full,
	output logic                         push,
	output dpalu_pkg::op_item_t          item
);

	logic [31:0] ins;
	logic [31:0] rn;
	logic [31:0] rm;
	logic [31:0] rs;
	logic [1:0]  kind;
	logic [4:0]  amt5;
	logic [32:0] lsl_ext;
	logic [32:0] lsr_ext;
	logic signed [32:0] asr_ext;
	logic [63:0] ror_w;
	logic [31:0] imm32;
	logic [63:0] imm_w;
	logic [31:0] sign_fill;
	logic        reg_big;

	assign ins = s_tdata[31:0];
	assign rn  = s_tdata[63:32];
	assign rm  = s_tdata[95:64];
	assign rs  = s_tdata[127:96];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// shift datapaths for amounts 1..31
	assign kind      = ins[6:5];
	assign amt5      = ins[4] ? rs[4:0] : ins[11:7];
	assign lsl_ext   = {1'b0, rm} << amt5;
	assign lsr_ext   = {rm, 1'b0} >> amt5;
	assign asr_ext   = $signed({rm, 1'b0}) >>> amt5;
	assign ror_w     = {rm, rm} >> amt5;
	assign sign_fill = {32{rm[31]}};
	assign reg_big   = (rs[7:5] != 3'd0);
	assign imm32     = {24'd0, ins[7:0]};
	assign imm_w     = {imm32, imm32} >> {ins[11:8], 1'b0};

	// operand 2 and shifter carry
	always_comb begin
		item.op2        = rm;
		item.shc        = 1'b0;
		item.shc_from_c = 1'b0;
		item.rrx        = 1'b0;
		if (ins[25]) begin
			item.op2 = imm_w[31:0];
			if (ins[11:8] == 4'd0) begin
				item.shc_from_c = 1'b1;
			end else begin
				item.shc = imm_w[31];
			end
		end else if (ins[4]) begin
			if (rs[7:0] == 8'd0) begin
				item.shc_from_c = 1'b1;
			end else begin
				case (kind)
					dpalu_pkg::SH_LSL: begin
						if (!reg_big) begin
							item.op2 = lsl_ext[31:0];
							item.shc = lsl_ext[32];
						end else begin
							item.op2 = '0;
							item.shc = (rs[7:0] == 8'd32) ? rm[0] : 1'b0;
						end
					end
					dpalu_pkg::SH_LSR: begin
						if (!reg_big) begin
							item.op2 = lsr_ext[32:1];
							item.shc = lsr_ext[0];
						end else begin
							item.op2 = '0;
							item.shc = (rs[7:0] == 8'd32) ? rm[31] : 1'b0;
						end
					end
					dpalu_pkg::SH_ASR: begin
						if (!reg_big) begin
							item.op2 = asr_ext[32:1];
							item.shc = asr_ext[0];
						end else begin
							item.op2 = sign_fill;
							item.shc = rm[31];
						end
					end
					default: begin
						// rotate by amount mod 32; zero passes Rm with carry bit 31
						item.op2 = ror_w[31:0];
						item.shc = ror_w[31];
					end
				endcase
			end
		end else begin
			case (kind)
				dpalu_pkg::SH_LSL: begin
					if (amt5 == 5'd0) begin
						item.shc_from_c = 1'b1;
					end else begin
						item.op2 = lsl_ext[31:0];
						item.shc = lsl_ext[32];
					end
				end
				dpalu_pkg::SH_LSR: begin
					if (amt5 == 5'd0) begin
						item.op2 = '0;
						item.shc = rm[31];
					end else begin
						item.op2 = lsr_ext[32:1];
						item.shc = lsr_ext[0];
					end
				end
				dpalu_pkg::SH_ASR: begin
					if (amt5 == 5'd0) begin
						item.op2 = sign_fill;
						item.shc = rm[31];
					end else begin
						item.op2 = asr_ext[32:1];
						item.shc = asr_ext[0];
					end
				end
				default: begin
					if (amt5 == 5'd0) begin
						// RRX: top bit filled from C in the back end
						item.op2 = {1'b0, rm[31:1]};
						item.shc = rm[0];
						item.rrx = 1'b1;
					end else begin
						item.op2 = ror_w[31:0];
						item.shc = ror_w[31];
					end
				end
			endcase
		end

		// opcode classification
		item.cond      = ins[31:28];
		item.rd        = ins[15:12];
		item.set_flags = ins[20];
		item.rn        = rn;
		item.writes    = 1'b1;
		item.fn        = dpalu_pkg::FN_ADD;
		item.swap      = 1'b0;
		item.invert    = 1'b0;
		item.cin_kind  = dpalu_pkg::CIN_ZERO;
		case (ins[24:21])
			dpalu_pkg::OP_AND: item.fn = dpalu_pkg::FN_AND;
			dpalu_pkg::OP_EOR: item.fn = dpalu_pkg::FN_EOR;
			dpalu_pkg::OP_SUB: begin
				item.invert   = 1'b1;
				item.cin_kind = dpalu_pkg::CIN_ONE;
			end
			dpalu_pkg::OP_RSB: begin
				item.swap     = 1'b1;
				item.invert   = 1'b1;
				item.cin_kind = dpalu_pkg::CIN_ONE;
			end
			dpalu_pkg::OP_ADD: item.cin_kind = dpalu_pkg::CIN_ZERO;
			dpalu_pkg::OP_ADC: item.cin_kind = dpalu_pkg::CIN_FLAG;
			dpalu_pkg::OP_SBC: begin
				item.invert   = 1'b1;
				item.cin_kind = dpalu_pkg::CIN_FLAG;
			end
			dpalu_pkg::OP_RSC: begin
				item.swap     = 1'b1;
				item.invert   = 1'b1;
				item.cin_kind = dpalu_pkg::CIN_FLAG;
			end
			dpalu_pkg::OP_TST: begin
				item.fn     = dpalu_pkg::FN_AND;
				item.writes = 1'b0;
			end
			dpalu_pkg::OP_TEQ: begin
				item.fn     = dpalu_pkg::FN_EOR;
				item.writes = 1'b0;
			end
			dpalu_pkg::OP_CMP: begin
				item.invert   = 1'b1;
				item.cin_kind = dpalu_pkg::CIN_ONE;
				item.writes   = 1'b0;
			end
			dpalu_pkg::OP_CMN: item.writes = 1'b0;
			dpalu_pkg::OP_ORR: item.fn = dpalu_pkg::FN_ORR;
			dpalu_pkg::OP_MOV: item.fn = dpalu_pkg::FN_MOV;
			dpalu_pkg::OP_BIC: item.fn = dpalu_pkg::FN_BIC;
			default:           item.fn = dpalu_pkg::FN_MVN;
		endcase
	end

endmodule

// ===== rtl/core/dpalu_queue.sv =====
// Small FIFO of decoded instructions between front and back end.
// Registered storage with read and write pointers and an occupancy count.
// Depends on dpalu_pkg.
module dpalu_queue #(
	parameter int unsigned DEPTH = dpalu_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dpalu_pkg::op_item_t push_item,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output dpalu_pkg::op_item_t head_item
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	dpalu_pkg::op_item_t entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/dpalu_back.sv =====
// Back end: condition check, ALU, NZCV flag register and the output register.
// Pops one decoded instruction per cycle while the output register can take it.
// Depends on dpalu_pkg.
module dpalu_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  dpalu_pkg::op_item_t            head_item,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_value, dest_index, write_enable, executed, flags_out, zero pad (lowest first)
	output logic [dpalu_pkg::OutDataW-1:0] m_tdata
);

	logic [3:0]  flags_q;
	logic        valid_q;
	logic [31:0] result_q;
	logic [3:0]  dest_q;
	logic        we_q;
	logic        exec_q;
	logic [3:0]  out_flags_q;

	logic        fn_n, fn_z, fn_c, fn_v;
	logic        pass;
	logic [31:0] op2;
	logic        shc;
	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_cin;
	logic [32:0] sum;
	logic        ovf;
	logic [31:0] res;
	logic        is_add;
	logic [3:0]  new_flags;

	assign fn_n = flags_q[3];
	assign fn_z = flags_q[2];
	assign fn_c = flags_q[1];
	assign fn_v = flags_q[0];

	// condition check against kept flags
	always_comb begin
		case (head_item.cond)
			dpalu_pkg::COND_EQ: pass = fn_z;
			dpalu_pkg::COND_NE: pass = !fn_z;
			dpalu_pkg::COND_CS: pass = fn_c;
			dpalu_pkg::COND_CC: pass = !fn_c;
			dpalu_pkg::COND_MI: pass = fn_n;
			dpalu_pkg::COND_PL: pass = !fn_n;
			dpalu_pkg::COND_VS: pass = fn_v;
			dpalu_pkg::COND_VC: pass = !fn_v;
			dpalu_pkg::COND_HI: pass = fn_c && !fn_z;
			dpalu_pkg::COND_LS: pass = !fn_c || fn_z;
			dpalu_pkg::COND_GE: pass = (fn_n == fn_v);
			dpalu_pkg::COND_LT: pass = (fn_n != fn_v);
			dpalu_pkg::COND_GT: pass = !fn_z && (fn_n == fn_v);
			dpalu_pkg::COND_LE: pass = fn_z || (fn_n != fn_v);
			default:            pass = 1'b1;
		endcase
	end

	// resolve carry-dependent shifter cases
	assign op2 = head_item.rrx ? {fn_c, head_item.op2[30:0]} : head_item.op2;
	assign shc = head_item.shc_from_c ? fn_c : head_item.shc;

	// adder
	always_comb begin
		case (head_item.cin_kind)
			dpalu_pkg::CIN_ONE:  add_cin = 1'b1;
			dpalu_pkg::CIN_FLAG: add_cin = fn_c;
			default:             add_cin = 1'b0;
		endcase
	end
	assign add_a = head_item.swap ? op2 : head_item.rn;
	assign add_b = head_item.invert ? ~(head_item.swap ? head_item.rn : op2)
	                                :  (head_item.swap ? head_item.rn : op2);
	assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
	assign ovf   = ((add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]));

	// function select
	always_comb begin
		case (head_item.fn)
			dpalu_pkg::FN_AND: res = head_item.rn & op2;
			dpalu_pkg::FN_EOR: res = head_item.rn ^ op2;
			dpalu_pkg::FN_ORR: res = head_item.rn | op2;
			dpalu_pkg::FN_MOV: res = op2;
			dpalu_pkg::FN_BIC: res = head_item.rn & ~op2;
			dpalu_pkg::FN_MVN: res = ~op2;
			default:           res = sum[31:0];
		endcase
	end

	assign is_add = (head_item.fn == dpalu_pkg::FN_ADD);

	// logical ops keep V and take C from the shifter
	always_comb begin
		if (pass && head_item.set_flags) begin
			new_flags = {res[31], (res == 32'd0), is_add ? sum[32] : shc,
			             is_add ? ovf : fn_v};
		end else begin
			new_flags = flags_q;
		end
	end

	assign pop = head_valid && (!valid_q || m_tready);

	// flags and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				flags_q <= new_flags;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			result_q    <= pass ? res : 32'd0;
			dest_q      <= head_item.rd;
			we_q        <= pass && head_item.writes;
			exec_q      <= pass;
			out_flags_q <= new_flags;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'd0, out_flags_q, exec_q, we_q, dest_q, result_q};

	// flags move only when an instruction is taken from the queue
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(flags_q))
		else $error("flags changed without an executed transfer");

	// reported flags match the kept flags while a result is pending
	a_flags_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (out_flags_q == flags_q))
		else $error("flags_out differs from flag register");

	// a skipped instruction writes nothing and returns zero
	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !exec_q) |-> (!we_q && (result_q == 32'd0)))
		else $error("skipped instruction produced a write or a value");

	// a failed condition leaves the flags as they were
	a_skip_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !pass) |=> (flags_q == $past(flags_q)))
		else $error("failed condition altered flags");

endmodule

// ===== rtl/core/arm_data_processing_alu_core.sv =====
// Top level of the ARM data-processing ALU core.
// Instantiates dpalu_front, dpalu_queue and dpalu_back; depends on dpalu_pkg.
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid / s_tready  instruction, first_value, second_value, shift_reg_value
// m_*      out  m_tvalid / m_tready  result_value, dest_index, write_enable, executed, flags_out
//
// One transfer per clock in each direction, sustained while m_tready stays high. The input
// transfer writes the decoded item into the queue; once the output register is free, the
// condition check and ALU run on the queue head and load the output register, which offers
// the result on m_*. The NZCV register is the only feedback.
// Reset clears the flags, the queue and the output valid. A stalled output holds
// its result while the queue keeps taking input until it holds QUEUE_DEPTH items.
module arm_data_processing_alu_core #(
	parameter int unsigned QUEUE_DEPTH = dpalu_pkg::QueueDepth
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// instruction, first_value, second_value, shift_reg_value (lowest first)
	input  logic [dpalu_pkg::InDataW-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_value, dest_index, write_enable, executed, flags_out, zero pad (lowest first)
	output logic [dpalu_pkg::OutDataW-1:0] m_tdata
);

	logic                q_full;
	logic                push;
	logic                pop;
	logic                head_valid;
	dpalu_pkg::op_item_t push_item;
	dpalu_pkg::op_item_t head_item;

	dpalu_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.item     (push_item)
	);

	dpalu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	dpalu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ===== tb/sv/tb_arm_data_processing_alu_core.sv =====
// Self-checking bench for arm_data_processing_alu_core: condition check, barrel shifter,
// all 16 ALU ops and NZCV feedback, predicted per input transfer and compared in order.
// Depends on dpalu_pkg and the RTL only.
module tb_arm_data_processing_alu_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] COND_AL    = 4'hE;
	localparam logic [3:0] COND_NV    = 4'hF;
	localparam int         QuietLimit = 2000;
	localparam int         RandItems  = 800;
	localparam int         ReportMax  = 10;

	// one instruction with its three register values
	typedef struct packed {
		logic [31:0] insn;
		logic [31:0] rn_val;
		logic [31:0] rm_val;
		logic [31:0] rs_val;
	} dp_item_t;

	// one execute-stage result
	typedef struct packed {
		logic [31:0] result;
		logic [3:0]  dest;
		logic        wr_en;
		logic        done;
		logic [3:0]  flags;
	} dp_result_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [dpalu_pkg::InDataW-1:0]  s_tdata  = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [dpalu_pkg::OutDataW-1:0] m_tdata;

	dp_item_t   insn_queue[$];
	dp_result_t due_results[$];
	logic [3:0] nzcv_model     = 4'd0;
	logic       in_taken       = 1'b0;
	int         items_taken    = 0;
	int         results_seen   = 0;
	int         fail_count     = 0;
	int         quiet_cycles   = 0;
	int         gap_left       = 0;
	int         hold_left      = 0;
	logic       long_hold_done = 1'b0;
	int         total_items;

	arm_data_processing_alu_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------- prediction ----------------

	function automatic logic [31:0] ror32(logic [31:0] x, logic [4:0] n);
		return (x >> n) | (x << (6'd32 - {1'b0, n}));
	endfunction

	function automatic logic cond_ok(logic [3:0] cc, logic [3:0] f);
		logic n, z, c, v;
		{n, z, c, v} = f;
		case (cc)
		dpalu_pkg::COND_EQ: return z;
		dpalu_pkg::COND_NE: return !z;
		dpalu_pkg::COND_CS: return c;
		dpalu_pkg::COND_CC: return !c;
		dpalu_pkg::COND_MI: return n;
		dpalu_pkg::COND_PL: return !n;
		dpalu_pkg::COND_VS: return v;
		dpalu_pkg::COND_VC: return !v;
		dpalu_pkg::COND_HI: return c && !z;
		dpalu_pkg::COND_LS: return !c || z;
		dpalu_pkg::COND_GE: return n == v;
		dpalu_pkg::COND_LT: return n != v;
		dpalu_pkg::COND_GT: return !z && (n == v);
		dpalu_pkg::COND_LE: return z || (n != v);
		default: return 1'b1;    // AL and NV
		endcase
	endfunction

	// operand 2 and shifter carry, returned as {carry, value}
	function automatic logic [32:0] form_op2(logic [31:0] insn, logic [31:0] rm,
			logic [7:0] ramt, logic c_old);
		logic [31:0] val;
		logic        cy;
		int          k;
		val = rm;
		cy  = c_old;
		if (insn[25]) begin
			// rotated 8-bit immediate
			val = ror32({24'd0, insn[7:0]}, {insn[11:8], 1'b0});
			cy  = (insn[11:8] == 4'd0) ? c_old : val[31];
		end else if (insn[4]) begin
			// amount from the low byte of Rs; zero passes Rm and C
			k = ramt;
			if (k != 0) begin
				case (insn[6:5])
				dpalu_pkg::SH_LSL: begin
					if (k < 32) begin
						val = rm << k;
						cy  = rm[32 - k];
					end else begin
						val = 32'd0;
						cy  = (k == 32) ? rm[0] : 1'b0;
					end
				end
				dpalu_pkg::SH_LSR: begin
					if (k < 32) begin
						val = rm >> k;
						cy  = rm[k - 1];
					end else begin
						val = 32'd0;
						cy  = (k == 32) ? rm[31] : 1'b0;
					end
				end
				dpalu_pkg::SH_ASR: begin
					if (k < 32) begin
						val = $signed(rm) >>> k;
						cy  = rm[k - 1];
					end else begin
						val = {32{rm[31]}};
						cy  = rm[31];
					end
				end
				default: begin
					k = ramt[4:0];
					if (k == 0) begin
						cy = rm[31];
					end else begin
						val = ror32(rm, ramt[4:0]);
						cy  = rm[k - 1];
					end
				end
				endcase
			end
		end else begin
			// 5-bit immediate amount; zero has a special meaning per kind
			k = insn[11:7];
			case (insn[6:5])
			dpalu_pkg::SH_LSL: begin
				if (k != 0) begin
					val = rm << k;
					cy  = rm[32 - k];
				end
			end
			dpalu_pkg::SH_LSR: begin
				val = (k == 0) ? 32'd0 : rm >> k;
				cy  = (k == 0) ? rm[31] : rm[k - 1];
			end
			dpalu_pkg::SH_ASR: begin
				if (k == 0) begin
					val = {32{rm[31]}};
					cy  = rm[31];
				end else begin
					val = $signed(rm) >>> k;
					cy  = rm[k - 1];
				end
			end
			default: begin
				if (k == 0) begin
					val = {c_old, rm[31:1]};    // RRX
					cy  = rm[0];
				end else begin
					val = ror32(rm, insn[11:7]);
					cy  = rm[k - 1];
				end
			end
			endcase
		end
		return {cy, val};
	endfunction

	// {overflow, carry, sum}
	function automatic logic [33:0] add32(logic [31:0] a, logic [31:0] b, logic cin);
		logic [32:0] s;
		logic        ov;
		s  = {1'b0, a} + {1'b0, b} + {32'd0, cin};
		ov = (a[31] ^ s[31]) & (b[31] ^ s[31]);
		return {ov, s};
	endfunction

	function automatic dp_result_t exec_data_proc(dp_item_t it, logic [3:0] nzcv);
		dp_result_t  res;
		logic [32:0] sh;
		logic [33:0] sum;
		logic [31:0] rn, op2, val;
		logic [3:0]  opc;
		logic        cy, ov, c_old, logic_op;
		res.dest   = it.insn[15:12];
		res.result = 32'd0;
		res.wr_en  = 1'b0;
		res.done   = 1'b0;
		res.flags  = nzcv;
		if (!cond_ok(it.insn[31:28], nzcv))
			return res;
		c_old    = nzcv[1];
		sh       = form_op2(it.insn, it.rm_val, it.rs_val[7:0], c_old);
		op2      = sh[31:0];
		cy       = sh[32];
		ov       = nzcv[0];
		rn       = it.rn_val;
		opc      = it.insn[24:21];
		logic_op = 1'b1;
		sum      = '0;
		val      = 32'd0;
		case (opc)
		dpalu_pkg::OP_AND, dpalu_pkg::OP_TST: val = rn & op2;
		dpalu_pkg::OP_EOR, dpalu_pkg::OP_TEQ: val = rn ^ op2;
		dpalu_pkg::OP_ORR:                    val = rn | op2;
		dpalu_pkg::OP_MOV:                    val = op2;
		dpalu_pkg::OP_BIC:                    val = rn & ~op2;
		dpalu_pkg::OP_MVN:                    val = ~op2;
		dpalu_pkg::OP_SUB, dpalu_pkg::OP_CMP: sum = add32(rn, ~op2, 1'b1);
		dpalu_pkg::OP_RSB:                    sum = add32(op2, ~rn, 1'b1);
		dpalu_pkg::OP_ADD, dpalu_pkg::OP_CMN: sum = add32(rn, op2, 1'b0);
		dpalu_pkg::OP_ADC:                    sum = add32(rn, op2, c_old);
		dpalu_pkg::OP_SBC:                    sum = add32(rn, ~op2, c_old);
		default:                              sum = add32(op2, ~rn, c_old);    // RSC
		endcase
		if (opc inside {dpalu_pkg::OP_SUB, dpalu_pkg::OP_RSB, dpalu_pkg::OP_ADD,
				dpalu_pkg::OP_ADC, dpalu_pkg::OP_SBC, dpalu_pkg::OP_RSC,
				dpalu_pkg::OP_CMP, dpalu_pkg::OP_CMN}) begin
			logic_op      = 1'b0;
			{ov, cy, val} = sum;
		end
		if (it.insn[20])
			res.flags = {val[31], val == 32'd0, cy, logic_op ? nzcv[0] : ov};
		res.result = val;
		res.wr_en  = !(opc inside {dpalu_pkg::OP_TST, dpalu_pkg::OP_TEQ,
			dpalu_pkg::OP_CMP, dpalu_pkg::OP_CMN});
		res.done   = 1'b1;
		return res;
	endfunction

	// ---------------- stimulus ----------------

	function automatic logic [31:0] dp_word(logic [3:0] cc, logic imm, logic [3:0] opc,
			logic s, logic [3:0] rd, logic [11:0] opnd);
		return {cc, 2'b00, imm, opc, s, 4'd1, rd, opnd};
	endfunction

	// Rm (r2) shifted by an immediate amount
	function automatic logic [11:0] sh_imm(logic [4:0] amt, logic [1:0] kind);
		return {amt, kind, 1'b0, 4'd2};
	endfunction

	// Rm (r2) shifted by Rs (r3)
	function automatic logic [11:0] sh_reg(logic [1:0] kind);
		return {4'd3, 1'b0, kind, 1'b1, 4'd2};
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
		0:       return 32'd0;
		1:       return 32'hFFFF_FFFF;
		2:       return 32'h8000_0000;
		3:       return 32'h7FFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	function automatic dp_item_t rand_item();
		dp_item_t it;
		it.insn   = $urandom;
		it.rn_val = rand_word();
		it.rm_val = rand_word();
		it.rs_val = $urandom;
		// shift amounts lean toward the edges
		case ($urandom_range(0, 11))
		0:       it.rs_val[7:0] = 8'd0;
		1:       it.rs_val[7:0] = 8'd32;
		2:       it.rs_val[7:0] = 8'($urandom_range(33, 255));
		3:       it.rs_val[7:0] = {3'($urandom_range(2, 7)), 5'd0};
		default: it.rs_val[7:0] = 8'($urandom_range(1, 31));
		endcase
		if ($urandom_range(0, 3) == 0)
			it.insn[11:7] = 5'd0;
		return it;
	endfunction

	task automatic add_item(logic [31:0] insn, logic [31:0] rn, logic [31:0] rm,
			logic [31:0] rs);
		insn_queue.push_back({insn, rn, rm, rs});
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ---------------- sender ----------------
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			// item still waiting for its transfer
		end else if (gap_left > 0) begin
			s_tvalid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (insn_queue.size() != 0) begin
			s_tdata  <= {insn_queue[0].rs_val, insn_queue[0].rm_val,
				insn_queue[0].rn_val, insn_queue[0].insn};
			s_tvalid <= 1'b1;
			void'(insn_queue.pop_front());
			gap_left <= ((items_taken / 120) % 3 == 1) ? 0 : pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// ---------------- receiver ----------------
	always @(negedge clk) begin : rx_drive
		int stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!long_hold_done && results_seen >= 200) begin
			// one long back-pressure stretch so the input side fills and stalls
			long_hold_done <= 1'b1;
			m_tready       <= 1'b0;
			hold_left      <= 79;
		end else begin
			stall = ((results_seen / 100) % 3 == 2) ? 0 : pick_gap();
			if (stall == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready  <= 1'b0;
				hold_left <= stall - 1;
			end
		end
	end

	// ---------------- monitor, checker and watchdog ----------------
	always @(posedge clk) begin : watch
		dp_item_t   got_in;
		dp_result_t got, want;
		if (arst_n) begin
			in_taken <= s_tvalid && s_tready;

			// result side: compare with the oldest prediction
			if (m_tvalid && m_tready) begin
				got.result   = m_tdata[31:0];
				got.dest     = m_tdata[35:32];
				got.wr_en    = m_tdata[36];
				got.done     = m_tdata[37];
				got.flags    = m_tdata[41:38];
				results_seen <= results_seen + 1;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= ReportMax)
						$display("%0t: result with nothing pending: %h", $realtime, m_tdata);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= ReportMax)
							$display("%0t: result %h/%h dest %h/%h we %b/%b exec %b/%b nzcv %b/%b",
								$realtime, want.result, got.result, want.dest, got.dest,
								want.wr_en, got.wr_en, want.done, got.done,
								want.flags, got.flags);
					end
				end
			end

			// input side: predict and keep the flags model in step
			if (s_tvalid && s_tready) begin
				got_in.insn   = s_tdata[31:0];
				got_in.rn_val = s_tdata[63:32];
				got_in.rm_val = s_tdata[95:64];
				got_in.rs_val = s_tdata[127:96];
				want          = exec_data_proc(got_in, nzcv_model);
				nzcv_model    = want.flags;
				due_results.push_back(want);
				items_taken++;
			end

			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("tb_arm_data_processing_alu_core failed");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------
	initial begin
		// flags and condition codes
		add_item(dp_word(COND_AL, 1'b1, dpalu_pkg::OP_MOV, 1'b1, 4'd0, 12'h000),
			32'd0, 32'd0, 32'd0);
		add_item(dp_word(dpalu_pkg::COND_EQ, 1'b1, dpalu_pkg::OP_ADD, 1'b1, 4'd1, 12'h001),
			32'h7FFF_FFFF, 32'd0, 32'd0);
		add_item(dp_word(dpalu_pkg::COND_LE, 1'b1, dpalu_pkg::OP_EOR, 1'b1, 4'd2, 12'h0F0),
			32'h1234_5678, 32'd0, 32'd0);
		add_item(dp_word(dpalu_pkg::COND_GT, 1'b0, dpalu_pkg::OP_ORR, 1'b0, 4'd3,
			sh_imm(5'd4, dpalu_pkg::SH_LSL)), 32'hA5A5_0000, 32'h0000_F00F, 32'd0);
		add_item(dp_word(dpalu_pkg::COND_PL, 1'b0, dpalu_pkg::OP_AND, 1'b1, 4'd4,
			sh_imm(5'd1, dpalu_pkg::SH_LSR)), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		// NV runs like AL; rotated immediate carries out bit 31
		add_item(dp_word(COND_NV, 1'b1, dpalu_pkg::OP_MOV, 1'b1, 4'd5, 12'h4FF),
			32'd0, 32'd0, 32'd0);
		add_item(dp_word(dpalu_pkg::COND_CS, 1'b1, dpalu_pkg::OP_AND, 1'b0, 4'd15, 12'hFFF),
			32'hFFFF_FFFF, 32'd0, 32'd0);
		// immediate shift amount zero, each kind
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_MOV, 1'b1, 4'd6,
			sh_imm(5'd0, dpalu_pkg::SH_LSL)), 32'd0, 32'hFFFF_FFFF, 32'd0);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_SUB, 1'b1, 4'd7,
			sh_imm(5'd0, dpalu_pkg::SH_LSR)), 32'd0, 32'h8000_0000, 32'd0);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_RSB, 1'b1, 4'd8,
			sh_imm(5'd0, dpalu_pkg::SH_ASR)), 32'd1, 32'h8000_0000, 32'd0);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_ADC, 1'b1, 4'd9,
			sh_imm(5'd0, dpalu_pkg::SH_ROR)), 32'hFFFF_FFFF, 32'd1, 32'd0);
		// register shift amounts zero, 31, 32 and above
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_SBC, 1'b1, 4'd10,
			sh_reg(dpalu_pkg::SH_LSL)), 32'd0, 32'd5, 32'h0000_0100);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_RSC, 1'b1, 4'd11,
			sh_reg(dpalu_pkg::SH_LSL)), 32'd7, 32'd3, 32'd32);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_TST, 1'b1, 4'd12,
			sh_reg(dpalu_pkg::SH_LSL)), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd33);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_TEQ, 1'b1, 4'd13,
			sh_reg(dpalu_pkg::SH_LSR)), 32'd0, 32'h8000_0000, 32'd32);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_CMP, 1'b1, 4'd14,
			sh_reg(dpalu_pkg::SH_LSR)), 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_CMN, 1'b1, 4'd0,
			sh_reg(dpalu_pkg::SH_ASR)), 32'd1, 32'h8000_0000, 32'd40);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_BIC, 1'b1, 4'd1,
			sh_reg(dpalu_pkg::SH_ROR)), 32'hFFFF_FFFF, 32'h8000_0001, 32'd64);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_MVN, 1'b1, 4'd2,
			sh_reg(dpalu_pkg::SH_ROR)), 32'd0, 32'd3, 32'h21);
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_ORR, 1'b1, 4'd3,
			sh_reg(dpalu_pkg::SH_ASR)), 32'd0, 32'h8000_0000, 32'd31);
		// carry and overflow extremes, then condition checks on them
		add_item(dp_word(COND_AL, 1'b0, dpalu_pkg::OP_ADD, 1'b1, 4'd4,
			sh_imm(5'd0, dpalu_pkg::SH_LSL)), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		add_item(dp_word(dpalu_pkg::COND_HI, 1'b0, dpalu_pkg::OP_SUB, 1'b1, 4'd5,
			sh_imm(5'd0, dpalu_pkg::SH_LSL)), 32'h8000_0000, 32'd1, 32'd0);
		add_item(dp_word(dpalu_pkg::COND_VS, 1'b0, dpalu_pkg::OP_MOV, 1'b0, 4'd6,
			sh_imm(5'd31, dpalu_pkg::SH_ROR)), 32'd0, 32'hFFFF_FFFF, 32'd0);
		add_item(dp_word(dpalu_pkg::COND_LS, 1'b0, dpalu_pkg::OP_MOV, 1'b0, 4'd7,
			sh_imm(5'd31, dpalu_pkg::SH_ASR)), 32'd0, 32'h8000_0000, 32'd0);
		for (int i = 0; i < RandItems; i++)
			insn_queue.push_back(rand_item());
		total_items = insn_queue.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_taken < total_items || due_results.size() != 0)
			@(posedge clk);
		// a stray result would show up within the pipeline latency
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("tb_arm_data_processing_alu_core passed");
		else
			$display("tb_arm_data_processing_alu_core failed");
		$finish;
	end

endmodule
